### hdl/bpa_pkg.sv
// Shared types, sizes and codes for the buddy page allocator.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bpa_pkg;

    localparam int TOTAL_PAGES = 16;
    localparam int LG_TOTAL    = $clog2(TOTAL_PAGES);
    localparam int NODE_CNT    = 2 * TOTAL_PAGES - 1;
    localparam int IDX_W       = $clog2(NODE_CNT);
    localparam int NODE_W      = $clog2(TOTAL_PAGES + 1) + 1;
    localparam int REQ_W       = 5;
    localparam int OFF_W       = 4;
    localparam int PAGES_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int LG_W        = $clog2(((LG_TOTAL > REQ_W) ? LG_TOTAL : REQ_W) + 2);

    localparam logic [NODE_W-1:0] ALLOC_MARK = '1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [REQ_W-1:0]   request_pages;
        logic [OFF_W-1:0]   free_offset;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    block_offset;
        logic [PAGES_W-1:0]  block_pages;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [NODE_W-1:0] wr_data;
    } t_ram_req;

    // log2 of the request rounded up to a power of two, zero taken as one
    function automatic logic [LG_W-1:0] ceil_lg(input logic [REQ_W-1:0] n);
        logic [REQ_W-1:0] m;
        logic [LG_W-1:0]  lg;
        begin
            m  = (n == '0) ? '0 : n - REQ_W'(1);
            lg = '0;
            for (int i = 0; i < REQ_W; i++) begin
                if (m[i]) begin
                    lg = LG_W'(i + 1);
                end
            end
            return lg;
        end
    endfunction

    function automatic logic [NODE_W-1:0] size_of(input logic [LG_W-1:0] lg);
        return NODE_W'(1) << lg;
    endfunction

    // first page covered by node idx whose block holds 2**lg pages
    function automatic logic [OFF_W-1:0] block_first(input logic [IDX_W-1:0] idx,
                                                     input logic [LG_W-1:0]  lg);
        logic [IDX_W-1:0] p;
        begin
            p = (idx + IDX_W'(1)) << lg;
            p = p - IDX_W'(TOTAL_PAGES);
            return OFF_W'(p);
        end
    endfunction

endpackage

`default_nettype wire

### hdl/bpa_node_ram.sv
// Node store of the buddy tree: one write and one registered read per cycle.
// Per-entry valid bits make unwritten nodes read as their reset value. Uses bpa_pkg.
`default_nettype none

module bpa_node_ram
    import bpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ram_req          i_req,
    output logic [NODE_W-1:0]      o_rd_data
);

    logic [NODE_W-1:0]   r_mem [NODE_CNT];
    logic [NODE_CNT-1:0] r_valid;
    logic [NODE_W-1:0]   r_rd_q;
    logic                r_rd_v;
    logic                r_rd_root;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_q    <= r_mem[i_req.rd_addr];
        r_rd_v    <= r_valid[i_req.rd_addr];
        r_rd_root <= (i_req.rd_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // root starts free with the whole range, every other node cleared
    assign o_rd_data = r_rd_v    ? r_rd_q :
                       r_rd_root ? NODE_W'(TOTAL_PAGES) : '0;

endmodule

`default_nettype wire

### hdl/bpa_ctrl.sv
// Sequencer of the buddy allocator: level scan, split, upward walk and merge.
// Drives the node store through read-modify-write beats. Uses bpa_pkg.
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_cmd              i_cmd,
    output logic                   o_busy,
    output logic                   o_done,
    output t_result                o_result,
    output t_ram_req               o_ram_req,
    input  wire logic [NODE_W-1:0] i_rd_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_SPLIT   = 4'd2;
    localparam logic [3:0] S_SPLIT_B = 4'd3;
    localparam logic [3:0] S_WALK    = 4'd4;
    localparam logic [3:0] S_M_RD    = 4'd5;
    localparam logic [3:0] S_M_CHK   = 4'd6;
    localparam logic [3:0] S_M_W1    = 4'd7;
    localparam logic [3:0] S_M_W2    = 4'd8;

    logic [3:0]        r_state,    n_state;
    logic              r_done,     n_done;
    t_result           r_result,   n_result;
    logic [IDX_W-1:0]  r_addr,     n_addr;
    logic [IDX_W-1:0]  r_first,    n_first;
    logic [LG_W-1:0]   r_lg,       n_lg;
    logic              r_scan_end, n_scan_end;
    logic              r_chk_vld,  n_chk_vld;
    logic              r_chk_last, n_chk_last;
    logic [IDX_W-1:0]  r_chk_addr, n_chk_addr;
    logic [LG_W-1:0]   r_chk_lg,   n_chk_lg;
    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic [NODE_W-1:0] r_cur,      n_cur;

    logic [NODE_W-1:0] need;
    logic [LG_W-1:0]   req_lg;
    logic [IDX_W-1:0]  buddy;
    logic [IDX_W-1:0]  parent;
    logic              hit;
    logic              found;

    assign need   = size_of(r_lg);
    assign req_lg = ceil_lg(i_cmd.request_pages);
    assign buddy  = r_idx[0] ? r_idx + IDX_W'(1) : r_idx - IDX_W'(1);
    assign parent = (r_idx - IDX_W'(1)) >> 1;
    assign hit    = r_chk_vld && (i_rd_data != ALLOC_MARK) && (i_rd_data >= need);
    assign found  = r_chk_vld && (i_rd_data == ALLOC_MARK);

    always_comb begin
        n_state    = r_state;
        n_done     = 1'b0;
        n_result   = r_result;
        n_addr     = r_addr;
        n_first    = r_first;
        n_lg       = r_lg;
        n_scan_end = r_scan_end;
        n_chk_vld  = r_chk_vld;
        n_chk_last = r_chk_last;
        n_chk_addr = r_chk_addr;
        n_chk_lg   = r_chk_lg;
        n_idx      = r_idx;
        n_cur      = r_cur;

        o_ram_req.rd_addr = r_addr;
        o_ram_req.wr_en   = 1'b0;
        o_ram_req.wr_addr = r_idx;
        o_ram_req.wr_data = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_chk_vld  = 1'b0;
                    n_scan_end = 1'b0;
                    if (i_cmd.opcode == OP_ALLOC) begin
                        if (req_lg > LG_W'(LG_TOTAL)) begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_TOO_LARGE, block_offset: '0,
                                         block_pages: '0};
                        end else begin
                            n_lg    = req_lg;
                            n_first = IDX_W'(TOTAL_PAGES >> req_lg) - IDX_W'(1);
                            n_addr  = IDX_W'(TOTAL_PAGES >> req_lg) - IDX_W'(1);
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (int'(i_cmd.free_offset) >= TOTAL_PAGES) begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_NOT_ALLOC, block_offset: '0,
                                         block_pages: '0};
                        end else begin
                            n_lg    = '0;
                            n_addr  = IDX_W'(i_cmd.free_offset) + IDX_W'(TOTAL_PAGES - 1);
                            n_state = S_WALK;
                        end
                    end
                end
            end

            // issue one node read a beat, check the one issued before
            S_SCAN: begin
                if (hit) begin
                    n_idx   = r_chk_addr;
                    n_cur   = i_rd_data;
                    n_state = S_SPLIT;
                end else if (r_chk_vld && r_chk_last) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_NO_BLOCK, block_offset: '0, block_pages: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_chk_addr = r_addr;
                    n_chk_vld  = !r_scan_end;
                    n_chk_last = (r_first == '0);
                    if (!r_scan_end) begin
                        if (r_addr == {r_first[IDX_W-2:0], 1'b0}) begin
                            // end of level: move up to the next larger size
                            if (r_first == '0) begin
                                n_scan_end = 1'b1;
                            end else begin
                                n_first = (r_first - IDX_W'(1)) >> 1;
                                n_addr  = (r_first - IDX_W'(1)) >> 1;
                            end
                        end else begin
                            n_addr = r_addr + IDX_W'(1);
                        end
                    end
                end
            end

            S_SPLIT: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_idx;
                if (r_cur <= need) begin
                    o_ram_req.wr_data = ALLOC_MARK;
                    n_done   = 1'b1;
                    n_result = '{status: ST_OK, block_offset: block_first(r_idx, r_lg),
                                 block_pages: PAGES_W'(need)};
                    n_state  = S_IDLE;
                end else begin
                    o_ram_req.wr_data = '0;
                    n_state = S_SPLIT_B;
                end
            end

            // right half becomes free, descend into the left half
            S_SPLIT_B: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = {r_idx[IDX_W-2:0], 1'b0} + IDX_W'(2);
                o_ram_req.wr_data = r_cur >> 1;
                n_idx   = {r_idx[IDX_W-2:0], 1'b0} + IDX_W'(1);
                n_cur   = r_cur >> 1;
                n_state = S_SPLIT;
            end

            S_WALK: begin
                if (found) begin
                    o_ram_req.wr_en   = 1'b1;
                    o_ram_req.wr_addr = r_chk_addr;
                    o_ram_req.wr_data = size_of(r_chk_lg);
                    n_done   = 1'b1;
                    n_result = '{status: ST_OK,
                                 block_offset: block_first(r_chk_addr, r_chk_lg),
                                 block_pages: PAGES_W'(size_of(r_chk_lg))};
                    n_idx    = r_chk_addr;
                    n_lg     = r_chk_lg;
                    n_state  = S_M_RD;
                end else if (r_chk_vld && r_chk_last) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_NOT_ALLOC, block_offset: '0, block_pages: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_chk_addr = r_addr;
                    n_chk_lg   = r_lg;
                    n_chk_vld  = !r_scan_end;
                    n_chk_last = (r_addr == '0);
                    if (!r_scan_end) begin
                        if (r_addr == '0) begin
                            n_scan_end = 1'b1;
                        end else begin
                            n_addr = (r_addr - IDX_W'(1)) >> 1;
                            n_lg   = r_lg + LG_W'(1);
                        end
                    end
                end
            end

            // the node at r_idx is known to hold need; only the buddy is read
            S_M_RD: begin
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    o_ram_req.rd_addr = buddy;
                    n_state = S_M_CHK;
                end
            end

            S_M_CHK: begin
                if (i_rd_data == need) begin
                    o_ram_req.wr_en   = 1'b1;
                    o_ram_req.wr_addr = parent;
                    o_ram_req.wr_data = size_of(r_lg + LG_W'(1));
                    n_state = S_M_W1;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_M_W1: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_idx;
                o_ram_req.wr_data = '0;
                n_state = S_M_W2;
            end

            S_M_W2: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = buddy;
                o_ram_req.wr_data = '0;
                n_idx   = parent;
                n_lg    = r_lg + LG_W'(1);
                n_state = S_M_RD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_scan_end <= 1'b0;
            r_chk_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_scan_end <= n_scan_end;
            r_chk_vld  <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result   <= n_result;
        r_addr     <= n_addr;
        r_first    <= n_first;
        r_lg       <= n_lg;
        r_chk_last <= n_chk_last;
        r_chk_addr <= n_chk_addr;
        r_chk_lg   <= n_chk_lg;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_ram_req.wr_en)
        else $error("node store written while idle");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state != S_IDLE || r_done))
        else $error("accepted beat neither answered nor started");

    a_split_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_cur >= need))
        else $error("split below requested size");

    a_ok_has_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.status == ST_OK) |-> (r_result.block_pages != '0))
        else $error("successful result with no pages");

endmodule

`default_nettype wire

### hdl/buddy_page_allocator_core.sv
// Buddy page allocator, 16 pages as a 31-node tree in one node store.
// Allocate: the scan reads one node a cycle, then two writes per split level;
// request too large: result the next cycle. Results cannot be stalled.
// Free: the walk goes up one node a cycle to the result, then the block stays busy merging:
// per level it reads and checks the buddy, then writes parent, node and buddy.
// Synchronous reset clears the valid bits of the store at once: no clearing pass.
`default_nettype none

module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    output logic      o_busy,
    output logic      o_done,
    output t_result   o_result
);

    t_ram_req          ram_req;
    logic [NODE_W-1:0] rd_data;

    bpa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_cmd     (i_cmd),
        .o_busy    (o_busy),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_ram_req (ram_req),
        .i_rd_data (rd_data)
    );

    bpa_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire
